>>> sv/dtes_pkg.sv
`timescale 1ns / 1ps

package dtes_pkg;

    // Field widths
    localparam int YEAR_W    = 7;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 5;
    localparam int HOURS_W   = 5;
    localparam int MINUTES_W = 6;
    localparam int SECONDS_W = 6;
    localparam int ELAPSED_W = 32;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_YEAR = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_DAY  = 2'd1;

    localparam logic [YEAR_W-1:0] BASE_YEAR_RESET = 7'd16;
    localparam logic [DAY_W-1:0]  BASE_DAY_RESET  = 5'd1;

    // Shared multiply-add unit operand widths
    localparam int MUL_W = 17;

    // Calendar constants
    localparam logic [MUL_W-1:0] DAYS_PER_YEAR = 17'd365;
    localparam logic [MUL_W-1:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [MUL_W-1:0] SIXTY         = 17'd60;
    localparam logic [MONTH_W-1:0] FEBRUARY    = 4'd2;
    localparam logic [MONTH_W-1:0] DECEMBER    = 4'd12;

    // Days in the year before the first of the given month (1..12)
    function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [8:0] d;
        begin
            unique case (m)
                4'd1:    d = 9'd0;
                4'd2:    d = 9'd31;
                4'd3:    d = 9'd59;
                4'd4:    d = 9'd90;
                4'd5:    d = 9'd120;
                4'd6:    d = 9'd151;
                4'd7:    d = 9'd181;
                4'd8:    d = 9'd212;
                4'd9:    d = 9'd243;
                4'd10:   d = 9'd273;
                4'd11:   d = 9'd304;
                default: d = 9'd334;
            endcase
            return d;
        end
    endfunction

    // Count of years divisible by 4 in [0, y)
    function automatic logic [5:0] leaps_below(input logic [YEAR_W-1:0] y);
        logic [7:0] t;
        begin
            t = {1'b0, y} + 8'd3;
            return t[7:2];
        end
    endfunction

endpackage

>>> sv/date_to_elapsed_seconds.sv
`timescale 1ns / 1ps

// Converts a two-digit-year calendar time to the seconds elapsed since
// January base_day of base_year, 00:00:00 (registers 0 and 1 of the config
// port, reset to year 16, day 1). Years divisible by 4, zero included, are
// leap. A date before the base gives before_base = 1 and elapsed_seconds = 0.
// Month 0 is taken as January and months above 12 as December; other fields
// are used as given. Each item runs through one shared 17x17 multiply-add
// unit under a small sequencer: days, hours*60+minutes, *60+seconds, then
// days*86400+time, in the states DAYS, HMIN, MSEC and TOTAL, and the result
// is presented in DONE (straight from DAYS when the date is before the base).
// One item is in flight at a time: new input is taken only back in idle.
// Configuration writes are always taken and must come only while idle.
module date_to_elapsed_seconds
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dtes_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dtes_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [dtes_pkg::YEAR_W-1:0]         year,
    input  logic [dtes_pkg::MONTH_W-1:0]        month,
    input  logic [dtes_pkg::DAY_W-1:0]          day,
    input  logic [dtes_pkg::HOURS_W-1:0]        hours,
    input  logic [dtes_pkg::MINUTES_W-1:0]      minutes,
    input  logic [dtes_pkg::SECONDS_W-1:0]      seconds,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [dtes_pkg::ELAPSED_W-1:0]      elapsed_seconds,
    output logic                                before_base
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DAYS  = 3'd1;
    localparam logic [2:0] ST_HMIN  = 3'd2;
    localparam logic [2:0] ST_MSEC  = 3'd3;
    localparam logic [2:0] ST_TOTAL = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;

    logic [dtes_pkg::YEAR_W-1:0] base_year_reg;
    logic [dtes_pkg::DAY_W-1:0]  base_day_reg;

    logic [dtes_pkg::YEAR_W-1:0]    year_reg;
    logic [dtes_pkg::MONTH_W-1:0]   month_reg;
    logic [dtes_pkg::DAY_W-1:0]     day_reg;
    logic [dtes_pkg::HOURS_W-1:0]   hours_reg;
    logic [dtes_pkg::MINUTES_W-1:0] minutes_reg;
    logic [dtes_pkg::SECONDS_W-1:0] seconds_reg;

    logic [dtes_pkg::MUL_W-1:0]     days_reg;
    logic [dtes_pkg::ELAPSED_W-1:0] acc_reg, acc_next;
    logic                           before_reg;

    logic [dtes_pkg::MUL_W-1:0]     op_a, op_b;
    logic [dtes_pkg::ELAPSED_W-1:0] addend;
    logic [2*dtes_pkg::MUL_W-1:0]   product;
    logic [dtes_pkg::ELAPSED_W-1:0] mac;

    logic [dtes_pkg::MONTH_W-1:0] month_fix;
    logic [5:0]                   leap_diff;
    logic                         leap_adj;
    logic [9:0]                   pos_days;
    logic signed [10:0]           extra_days;
    logic                         year_early;

    logic in_xfer, out_xfer, cfg_xfer;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_DONE);
    assign cfg_ready = 1'b1;
    assign in_xfer   = in_valid && in_ready;
    assign out_xfer  = out_valid && out_ready;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    assign elapsed_seconds = acc_reg;
    assign before_base     = before_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_year_reg <= dtes_pkg::BASE_YEAR_RESET;
            base_day_reg  <= dtes_pkg::BASE_DAY_RESET;
        end
        else if (cfg_xfer)
        begin
            if (cfg_index == dtes_pkg::CFG_BASE_YEAR)
            begin
                base_year_reg <= cfg_data[dtes_pkg::YEAR_W-1:0];
            end
            else if (cfg_index == dtes_pkg::CFG_BASE_DAY)
            begin
                base_day_reg <= cfg_data[dtes_pkg::DAY_W-1:0];
            end
        end
    end

    // Day offset within the span: leap days, month, day of month
    always_comb
    begin
        if (month_reg == 4'd0)
        begin
            month_fix = 4'd1;
        end
        else if (month_reg > dtes_pkg::DECEMBER)
        begin
            month_fix = dtes_pkg::DECEMBER;
        end
        else
        begin
            month_fix = month_reg;
        end
        year_early = (year_reg < base_year_reg);
        leap_diff  = dtes_pkg::leaps_below(year_reg) - dtes_pkg::leaps_below(base_year_reg);
        leap_adj   = (month_fix > dtes_pkg::FEBRUARY) && (year_reg[1:0] == 2'b00);
        pos_days   = {4'd0, leap_diff} + {1'b0, dtes_pkg::days_before_month(month_fix)}
                   + {9'd0, leap_adj} + {5'd0, day_reg};
        extra_days = $signed({1'b0, pos_days}) - $signed({6'd0, base_day_reg});
    end

    // Shared multiply-add unit operand selection
    always_comb
    begin
        op_a   = '0;
        op_b   = '0;
        addend = '0;
        unique case (state_reg)
            ST_DAYS:
            begin
                op_a   = {10'd0, year_reg - base_year_reg};
                op_b   = dtes_pkg::DAYS_PER_YEAR;
                addend = {{21{extra_days[10]}}, extra_days};
            end
            ST_HMIN:
            begin
                op_a   = {12'd0, hours_reg};
                op_b   = dtes_pkg::SIXTY;
                addend = {26'd0, minutes_reg};
            end
            ST_MSEC:
            begin
                op_a   = acc_reg[dtes_pkg::MUL_W-1:0];
                op_b   = dtes_pkg::SIXTY;
                addend = {26'd0, seconds_reg};
            end
            ST_TOTAL:
            begin
                op_a   = days_reg;
                op_b   = dtes_pkg::SECS_PER_DAY;
                addend = acc_reg;
            end
            default:
            begin
                op_a   = '0;
                op_b   = '0;
                addend = '0;
            end
        endcase
        product = op_a * op_b;
        mac     = product[dtes_pkg::ELAPSED_W-1:0] + addend;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_DAYS;
                end
            end
            ST_DAYS:
            begin
                if (year_early || mac[dtes_pkg::ELAPSED_W-1])
                begin
                    acc_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_HMIN;
                end
            end
            ST_HMIN:
            begin
                acc_next   = mac;
                state_next = ST_MSEC;
            end
            ST_MSEC:
            begin
                acc_next   = mac;
                state_next = ST_TOTAL;
            end
            ST_TOTAL:
            begin
                acc_next   = mac;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_xfer)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            before_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DAYS)
            begin
                before_reg <= year_early || mac[dtes_pkg::ELAPSED_W-1];
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (in_xfer)
        begin
            year_reg    <= year;
            month_reg   <= month;
            day_reg     <= day;
            hours_reg   <= hours;
            minutes_reg <= minutes;
            seconds_reg <= seconds;
        end
        if (state_reg == ST_DAYS)
        begin
            days_reg <= mac[dtes_pkg::MUL_W-1:0];
        end
    end

`ifndef SYNTHESIS
    // One item in flight: input side closed while a result waits
    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("input accepted while result pending");

    // A date before the base always reports zero seconds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && before_base) |-> (elapsed_seconds == '0))
        else $error("before_base result with nonzero seconds");

    // An input transfer starts the sequencer and closes the input side
    assert property (@(posedge clk) disable iff (!rst_n) in_xfer |=> !in_ready && !out_valid)
        else $error("sequencer did not start after input transfer");

    // A result stays presented until its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(elapsed_seconds))
        else $error("result dropped before transfer");
`endif

endmodule
